### sv/slr_pkg.sv
package slr_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int FRAC_W     = 16;
   localparam int PHASE_W    = 21;
   localparam int RESULT_CAP = 16;
   localparam int COUNT_W    = $clog2(RESULT_CAP);
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;

   localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_W'(384000);
   localparam logic [PHASE_W-1:0] PHASE_MAX  = {PHASE_W{1'b1}};
   localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_W;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       last_of_run;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;   // take the new frame, clear the run count
      logic mul;     // register the interpolation products
      logic emit;    // load the result register, advance phase
      logic finish;  // wrap phase, new frame becomes previous
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic below_one;  // phase < 1
      logic last;       // the result formed now ends the run
      logic out_free;   // result register can take an item this cycle
   } dp_status_type;

endpackage

### sv/stereo_linear_resampler.sv
// A frame is accepted in the idle state; for each result the products are registered in a
// multiply state, and the result is loaded in an emit state that stalls on a full register.
// A frame yields n = 0..16 results from the controller's loop and holds the block until its
// run ends. A held result register lets the next frame in while the last result waits.
// Reset (synchronous): step 384000, phase and previous frame zero, result register empty.
module stereo_linear_resampler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  slr_pkg::req_payload_type        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output slr_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [slr_pkg::PHASE_W-1:0]     csr_wdata
);

   slr_pkg::dp_cmd_type    cmd;
   slr_pkg::dp_status_type status;

   // step register is always writable; the source must write it only while
   // no frame is in flight, and the block itself does not enforce this
   assign csr_ready = 1'b1;

   // sequencer: accept a frame, loop multiply/emit while phase < 1 and
   // under the cap, then wrap phase and keep the frame
   slr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // phase, step, previous/new frame, product registers and result register
   slr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### sv/slr_datapath.sv
module slr_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  slr_pkg::dp_cmd_type             cmd,
   output slr_pkg::dp_status_type          status,
   input  slr_pkg::req_payload_type        req_payload,
   input  logic                            csr_valid,
   input  logic [slr_pkg::PHASE_W-1:0]     csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output slr_pkg::rsp_payload_type        rsp_payload
);

   localparam int NUM_W = slr_pkg::SAMPLE_W + slr_pkg::FRAC_W + 2;

   logic [slr_pkg::PHASE_W-1:0]         step_ff;
   logic [slr_pkg::PHASE_W-1:0]         phase_ff, phase_in;
   logic signed [slr_pkg::SAMPLE_W-1:0] prev_l_ff, prev_r_ff;
   logic signed [slr_pkg::SAMPLE_W-1:0] new_l_ff, new_r_ff;
   logic signed [slr_pkg::PROD_W-1:0]   prod_l_ff, prod_r_ff;
   logic [slr_pkg::COUNT_W-1:0]         count_ff;
   logic                                rsp_valid_ff;
   slr_pkg::rsp_payload_type            rsp_ff, rsp_in;
   logic [slr_pkg::PHASE_W:0]           sum;
   logic [slr_pkg::PHASE_W-1:0]         sat;
   logic signed [slr_pkg::PROD_W-1:0]   mul_l, mul_r;

   // prev + (new - prev) * frac / 2^16, truncated toward zero
   function automatic logic signed [slr_pkg::SAMPLE_W-1:0] lerp_out(
      input logic signed [slr_pkg::SAMPLE_W-1:0] prev,
      input logic signed [slr_pkg::PROD_W-1:0]   prod
   );
      logic signed [NUM_W-1:0]                   num;
      logic [NUM_W-slr_pkg::FRAC_W-1:0]          q;
      num = $signed({{2{prev[slr_pkg::SAMPLE_W-1]}}, prev, {slr_pkg::FRAC_W{1'b0}}})
            + NUM_W'(prod);
      q = num[NUM_W-1:slr_pkg::FRAC_W];
      if (num[NUM_W-1] && (|num[slr_pkg::FRAC_W-1:0])) begin
         q = q + 1'b1;
      end
      return q[slr_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [slr_pkg::PROD_W-1:0] diff_mul(
      input logic signed [slr_pkg::SAMPLE_W-1:0] prev,
      input logic signed [slr_pkg::SAMPLE_W-1:0] nxt,
      input logic [slr_pkg::FRAC_W-1:0]          frac
   );
      logic signed [slr_pkg::DIFF_W-1:0] diff;
      diff = slr_pkg::DIFF_W'(nxt) - slr_pkg::DIFF_W'(prev);
      return diff * $signed({1'b0, frac});
   endfunction

   assign mul_l = diff_mul(prev_l_ff, new_l_ff, phase_ff[slr_pkg::FRAC_W-1:0]);
   assign mul_r = diff_mul(prev_r_ff, new_r_ff, phase_ff[slr_pkg::FRAC_W-1:0]);

   assign sum = {1'b0, phase_ff} + {1'b0, step_ff};
   assign sat = sum[slr_pkg::PHASE_W] ? slr_pkg::PHASE_MAX : sum[slr_pkg::PHASE_W-1:0];

   assign status.below_one = ~|phase_ff[slr_pkg::PHASE_W-1:slr_pkg::FRAC_W];
   assign status.last      = (count_ff == slr_pkg::COUNT_W'(slr_pkg::RESULT_CAP - 1))
                             || (|sat[slr_pkg::PHASE_W-1:slr_pkg::FRAC_W]);
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      phase_in = phase_ff;
      if (cmd.emit) begin
         phase_in = sat;
      end else if (cmd.finish) begin
         phase_in = status.below_one ? '0 : phase_ff - slr_pkg::PHASE_ONE;
      end
   end

   always_comb begin
      rsp_in.left_out    = lerp_out(prev_l_ff, prod_l_ff);
      rsp_in.right_out   = lerp_out(prev_r_ff, prod_r_ff);
      rsp_in.last_of_run = status.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= slr_pkg::STEP_RESET;
         phase_ff     <= '0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            step_ff <= csr_wdata;
         end
         phase_ff <= phase_in;
         if (cmd.finish) begin
            prev_l_ff <= new_l_ff;
            prev_r_ff <= new_r_ff;
         end
         if (cmd.latch) begin
            count_ff <= '0;
         end else if (cmd.emit) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         new_l_ff <= req_payload.left_sample;
         new_r_ff <= req_payload.right_sample;
      end
      if (cmd.mul) begin
         prod_l_ff <= mul_l;
         prod_r_ff <= mul_r;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded over an unaccepted item");

   a_cap_ends_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !status.last) |->
         (count_ff != slr_pkg::COUNT_W'(slr_pkg::RESULT_CAP - 1)))
      else $error("run went past the result cap");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("result appeared without an emit");

endmodule

### sv/slr_ctrl.sv
module slr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  slr_pkg::dp_status_type  status,
   output slr_pkg::dp_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = status.below_one ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last ? ST_DONE : ST_MUL;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.latch, cmd.mul, cmd.emit, cmd.finish}))
      else $error("more than one datapath command");

   a_last_then_finish: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last) |=> cmd.finish)
      else $error("run ended without wrapping phase");

endmodule
